>>> src/ttcw_pkg.sv
package ttcw_pkg;

  // Default geometry of the console
  localparam int unsigned LINE_WIDTH_DEF = 31;
  localparam int unsigned LINE_COUNT_DEF = 24;
  localparam int unsigned WRAP_ROWS_DEF  = 28;

  // Field widths
  localparam int unsigned OP_W     = 2;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned POS_W    = 5;
  localparam int unsigned OFS_W    = 11;
  localparam int unsigned TILE_W   = 7;
  localparam int unsigned SCROLL_W = 8;

  // Command codes
  localparam logic [OP_W-1:0] OP_PUT_CHAR = 2'd0;
  localparam logic [OP_W-1:0] OP_PUT_HEX  = 2'd1;
  localparam logic [OP_W-1:0] OP_GOTO     = 2'd2;
  localparam logic [OP_W-1:0] OP_MOVE     = 2'd3;

  // Result kinds
  localparam logic KIND_CELL   = 1'b0;
  localparam logic KIND_SCROLL = 1'b1;

  // Character codes
  localparam logic [BYTE_W-1:0] CHAR_NEWLINE   = 8'h0A;
  localparam logic [BYTE_W-1:0] CHAR_FIRST     = 8'h20;
  localparam logic [BYTE_W-1:0] CHAR_LAST      = 8'h7F;
  localparam logic [BYTE_W-1:0] CHAR_QUESTION  = 8'h3F;
  localparam logic [BYTE_W-1:0] CHAR_HEX_DIGIT = 8'h30;
  localparam logic [BYTE_W-1:0] CHAR_HEX_ALPHA = 8'h41;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic adv;
    logic emit_blank;
    logic emit_scroll;
    logic emit_char;
    logic clamp;
    logic mod_step;
    logic set_ofs;
    logic last;
  } ttcw_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic out_free;
    logic is_newline;
    logic at_line_end;
    logic row_hit;
    logic blank_done;
    logic hex_pend;
    logic mod_ge;
  } ttcw_sts_t;

  function automatic logic [BYTE_W-1:0] hex_ascii(input logic [3:0] nib);
    logic [BYTE_W-1:0] wide;
    wide = {4'b0, nib};
    if (nib > 4'd9) begin
      return wide - 8'd10 + CHAR_HEX_ALPHA;
    end
    return wide + CHAR_HEX_DIGIT;
  endfunction

  function automatic logic [TILE_W-1:0] tile_of(input logic [BYTE_W-1:0] code);
    logic [BYTE_W-1:0] diff;
    if (code < CHAR_FIRST || code > CHAR_LAST) begin
      diff = CHAR_QUESTION - CHAR_FIRST;
    end else begin
      diff = code - CHAR_FIRST;
    end
    return diff[TILE_W-1:0];
  endfunction

endpackage

>>> src/ttcw_cmd_if.sv
interface ttcw_cmd_if import ttcw_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] char_code;
  logic [BYTE_W-1:0] col;
  logic [BYTE_W-1:0] row;

  modport source (output valid, output op, output char_code, output col, output row,
                  input ready);
  modport sink   (input valid, input op, input char_code, input col, input row,
                  output ready);
endinterface

>>> src/ttcw_res_if.sv
interface ttcw_res_if import ttcw_pkg::*; ();
  logic                valid;
  logic                ready;
  logic                kind;
  logic [OFS_W-1:0]    cell_offset;
  logic [TILE_W-1:0]   tile;
  logic [SCROLL_W-1:0] scroll_value;
  logic                last;

  modport source (output valid, output kind, output cell_offset, output tile,
                  output scroll_value, output last, input ready);
  modport sink   (input valid, input kind, input cell_offset, input tile,
                  input scroll_value, input last, output ready);
endinterface

>>> src/ttcw_ctrl.sv
module ttcw_ctrl import ttcw_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cmd_valid_i,
  input  logic [OP_W-1:0] cmd_op_i,
  output logic            cmd_ready_o,
  input  ttcw_sts_t       sts_i,
  output ttcw_cmd_t       cmd_o
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_CHAR   = 4'd1;
  localparam logic [3:0] S_ADV    = 4'd2;
  localparam logic [3:0] S_BLANK  = 4'd3;
  localparam logic [3:0] S_SCROLL = 4'd4;
  localparam logic [3:0] S_DRAW   = 4'd5;
  localparam logic [3:0] S_CLAMP  = 4'd6;
  localparam logic [3:0] S_MOD    = 4'd7;
  localparam logic [3:0] S_OFS    = 4'd8;

  logic [3:0] state_q, state_d;
  logic       draw_after_q, draw_after_d;

  always_comb begin
    state_d      = state_q;
    draw_after_d = draw_after_q;
    cmd_o        = '0;
    cmd_ready_o  = 1'b0;
    case (state_q)
      S_IDLE: begin
        cmd_ready_o = 1'b1;
        if (cmd_valid_i) begin
          cmd_o.load = 1'b1;
          if (cmd_op_i == OP_PUT_CHAR || cmd_op_i == OP_PUT_HEX) begin
            state_d = S_CHAR;
          end else begin
            state_d = S_CLAMP;
          end
        end
      end
      S_CHAR: begin
        if (sts_i.is_newline) begin
          draw_after_d = 1'b0;
          state_d      = S_ADV;
        end else if (sts_i.at_line_end) begin
          draw_after_d = 1'b1;
          state_d      = S_ADV;
        end else begin
          state_d = S_DRAW;
        end
      end
      S_ADV: begin
        cmd_o.adv = 1'b1;
        if (sts_i.row_hit) begin
          state_d = S_BLANK;
        end else if (draw_after_q) begin
          state_d = S_DRAW;
        end else begin
          state_d = S_IDLE;
        end
      end
      S_BLANK: begin
        if (sts_i.out_free) begin
          cmd_o.emit_blank = 1'b1;
          if (sts_i.blank_done) begin
            state_d = S_SCROLL;
          end
        end
      end
      S_SCROLL: begin
        if (sts_i.out_free) begin
          cmd_o.emit_scroll = 1'b1;
          cmd_o.last        = !draw_after_q;
          state_d           = draw_after_q ? S_DRAW : S_IDLE;
        end
      end
      S_DRAW: begin
        if (sts_i.out_free) begin
          cmd_o.emit_char = 1'b1;
          cmd_o.last      = !sts_i.hex_pend;
          state_d         = sts_i.hex_pend ? S_CHAR : S_IDLE;
        end
      end
      S_CLAMP: begin
        cmd_o.clamp = 1'b1;
        state_d     = S_MOD;
      end
      S_MOD: begin
        if (sts_i.mod_ge) begin
          cmd_o.mod_step = 1'b1;
        end else begin
          state_d = S_OFS;
        end
      end
      S_OFS: begin
        cmd_o.set_ofs = 1'b1;
        state_d       = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      draw_after_q <= 1'b0;
    end else begin
      state_q      <= state_d;
      draw_after_q <= draw_after_d;
    end
  end

endmodule

>>> src/ttcw_dp.sv
module ttcw_dp import ttcw_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int unsigned LINE_COUNT = LINE_COUNT_DEF,
  parameter int unsigned WRAP_ROWS  = WRAP_ROWS_DEF
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [OP_W-1:0]     cmd_op_i,
  input  logic [BYTE_W-1:0]   cmd_char_code_i,
  input  logic [BYTE_W-1:0]   cmd_col_i,
  input  logic [BYTE_W-1:0]   cmd_row_i,
  input  ttcw_cmd_t           cmd_i,
  output ttcw_sts_t           sts_o,
  input  logic                res_ready_i,
  output logic                res_valid_o,
  output logic                res_kind_o,
  output logic [OFS_W-1:0]    res_cell_offset_o,
  output logic [TILE_W-1:0]   res_tile_o,
  output logic [SCROLL_W-1:0] res_scroll_value_o,
  output logic                res_last_o
);

  localparam logic [POS_W-1:0]   LW         = POS_W'(LINE_WIDTH);
  localparam logic [POS_W-1:0]   LW_M1      = POS_W'(LINE_WIDTH - 1);
  localparam logic [BYTE_W-1:0]  LW_B       = BYTE_W'(LINE_WIDTH);
  localparam logic [BYTE_W-1:0]  LC_B       = BYTE_W'(LINE_COUNT);
  localparam logic [POS_W-1:0]   LC_M1      = POS_W'(LINE_COUNT - 1);
  localparam logic [POS_W:0]     LC6        = (POS_W+1)'(LINE_COUNT);
  localparam logic [POS_W:0]     WR6        = (POS_W+1)'(WRAP_ROWS);
  localparam logic [POS_W-1:0]   SR_MAX     = POS_W'(WRAP_ROWS - 1);
  localparam logic [POS_W:0]     PITCH      = (POS_W+1)'(LINE_WIDTH + 1);
  localparam logic [OFS_W:0]     WRAP_LIMIT = (OFS_W+1)'(2 * (WRAP_ROWS - 1) * (LINE_WIDTH + 1));

  // Architectural state
  logic [POS_W-1:0] cur_col_q, cur_col_d;
  logic [POS_W-1:0] cur_row_q, cur_row_d;
  logic [OFS_W-1:0] wo_q, wo_d;
  logic [POS_W-1:0] sr_q, sr_d;
  logic             hex_pend_q, hex_pend_d;

  // Working registers
  logic [OP_W-1:0]   op_q;
  logic [BYTE_W-1:0] byte_q;
  logic [BYTE_W-1:0] col_in_q;
  logic [BYTE_W-1:0] row_in_q;
  logic [BYTE_W-1:0] code_q, code_d;
  logic [OFS_W-1:0]  blk_ofs_q, blk_ofs_d;
  logic [POS_W-1:0]  blk_cnt_q, blk_cnt_d;
  logic [POS_W:0]    mrow_q, mrow_d;

  // Result register
  logic                res_valid_q;
  logic                kind_q;
  logic [OFS_W-1:0]    ofs_q;
  logic [TILE_W-1:0]   tile_q;
  logic [SCROLL_W-1:0] sv_q;
  logic                last_q;

  logic [POS_W:0]    adv_cells;
  logic [OFS_W:0]    adv_sum;
  logic [OFS_W-1:0]  adv_ofs;
  logic              row_hit;
  logic [BYTE_W-1:0] x_raw, y_raw;
  logic [POS_W-1:0]  x_clamp, y_clamp;
  logic [OFS_W-1:0]  row_base;
  logic [OFS_W-1:0]  row_sum;
  logic              emit_any;

  // Newline: skip the rest of the row, fold back to the top past the last row
  assign adv_cells = PITCH - {1'b0, cur_col_q};
  assign adv_sum   = {1'b0, wo_q} + {{(OFS_W-POS_W-1){1'b0}}, adv_cells, 1'b0};
  assign adv_ofs   = (adv_sum > WRAP_LIMIT) ? '0 : adv_sum[OFS_W-1:0];
  assign row_hit   = ({1'b0, cur_row_q} + 1'b1) == LC6;

  // Goto and move targets, saturated to the visible area
  assign x_raw   = (op_q == OP_GOTO) ? col_in_q : col_in_q + {3'b0, cur_col_q};
  assign y_raw   = (op_q == OP_GOTO) ? row_in_q : row_in_q + {3'b0, cur_row_q};
  assign x_clamp = (x_raw >= LW_B) ? LW_M1 : x_raw[POS_W-1:0];
  assign y_clamp = (y_raw >= LC_B) ? LC_M1 : y_raw[POS_W-1:0];

  assign row_base = OFS_W'(mrow_q[POS_W-1:0]) * OFS_W'(PITCH);
  assign row_sum  = row_base + OFS_W'(cur_col_q);

  assign emit_any = cmd_i.emit_blank | cmd_i.emit_scroll | cmd_i.emit_char;

  always_comb begin
    cur_col_d  = cur_col_q;
    cur_row_d  = cur_row_q;
    wo_d       = wo_q;
    sr_d       = sr_q;
    hex_pend_d = hex_pend_q;
    code_d     = code_q;
    blk_ofs_d  = blk_ofs_q;
    blk_cnt_d  = blk_cnt_q;
    mrow_d     = mrow_q;
    if (cmd_i.load) begin
      hex_pend_d = (cmd_op_i == OP_PUT_HEX);
      code_d     = (cmd_op_i == OP_PUT_HEX) ? hex_ascii(cmd_char_code_i[7:4]) : cmd_char_code_i;
    end
    if (cmd_i.adv) begin
      wo_d      = adv_ofs;
      blk_ofs_d = adv_ofs;
      blk_cnt_d = '0;
      cur_col_d = '0;
      if (row_hit) begin
        sr_d = (sr_q == SR_MAX) ? '0 : sr_q + 1'b1;
      end else begin
        cur_row_d = cur_row_q + 1'b1;
      end
    end
    if (cmd_i.emit_blank) begin
      blk_ofs_d = blk_ofs_q + OFS_W'(2);
      blk_cnt_d = blk_cnt_q + 1'b1;
    end
    if (cmd_i.emit_char) begin
      wo_d      = wo_q + OFS_W'(2);
      cur_col_d = cur_col_q + 1'b1;
      if (hex_pend_q) begin
        code_d     = hex_ascii(byte_q[3:0]);
        hex_pend_d = 1'b0;
      end
    end
    if (cmd_i.clamp) begin
      cur_col_d = x_clamp;
      cur_row_d = y_clamp;
      mrow_d    = {1'b0, y_clamp} + {1'b0, sr_q};
    end
    if (cmd_i.mod_step) begin
      mrow_d = mrow_q - WR6;
    end
    if (cmd_i.set_ofs) begin
      wo_d = {row_sum[OFS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cur_col_q   <= '0;
      cur_row_q   <= '0;
      wo_q        <= '0;
      sr_q        <= '0;
      hex_pend_q  <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      cur_col_q  <= cur_col_d;
      cur_row_q  <= cur_row_d;
      wo_q       <= wo_d;
      sr_q       <= sr_d;
      hex_pend_q <= hex_pend_d;
      if (emit_any) begin
        res_valid_q <= 1'b1;
      end else if (res_ready_i) begin
        res_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q     <= cmd_op_i;
      byte_q   <= cmd_char_code_i;
      col_in_q <= cmd_col_i;
      row_in_q <= cmd_row_i;
    end
    code_q    <= code_d;
    blk_ofs_q <= blk_ofs_d;
    blk_cnt_q <= blk_cnt_d;
    mrow_q    <= mrow_d;
    if (emit_any) begin
      kind_q <= cmd_i.emit_scroll ? KIND_SCROLL : KIND_CELL;
      ofs_q  <= cmd_i.emit_char ? wo_q : (cmd_i.emit_blank ? blk_ofs_q : '0);
      tile_q <= cmd_i.emit_char ? tile_of(code_q) : '0;
      sv_q   <= cmd_i.emit_scroll ? {sr_q, 3'b0} : '0;
      last_q <= cmd_i.last;
    end
  end

  assign sts_o.out_free    = !res_valid_q || res_ready_i;
  assign sts_o.is_newline  = (code_q == CHAR_NEWLINE);
  assign sts_o.at_line_end = (cur_col_q == LW);
  assign sts_o.row_hit     = row_hit;
  assign sts_o.blank_done  = (blk_cnt_q == LW_M1);
  assign sts_o.hex_pend    = hex_pend_q;
  assign sts_o.mod_ge      = (mrow_q >= WR6);

  assign res_valid_o        = res_valid_q;
  assign res_kind_o         = kind_q;
  assign res_cell_offset_o  = ofs_q;
  assign res_tile_o         = tile_q;
  assign res_scroll_value_o = sv_q;
  assign res_last_o         = last_q;

endmodule

>>> src/tile_text_console_writer_core.sv
// Text console on a vertically scrolled tile map. Each command word on cmd_i
// (put character, put byte as two hex digits, goto, relative move) turns into
// zero or more result words on res_o: name-table cell writes (byte offset from
// the table base, tile = code - 0x20, unprintable codes shown as '?') and
// vertical-scroll register writes (scroll index times eight); last marks the
// final word of a command. One command is worked at a time by a small
// sequencer. A plain character is checked for line end and then drawn; a
// hex byte does so for each digit; goto and move clamp, subtract WRAP_ROWS
// while the screen row is wrapped, then set the write offset. A newline
// that runs off the bottom line adds LINE_WIDTH + 1 words, emitted one per
// cycle from the single output register, which sets the pace whenever
// res_o stalls and holds the final word while the next command is accepted.
module tile_text_console_writer_core import ttcw_pkg::*; #(
  parameter int unsigned LINE_WIDTH = LINE_WIDTH_DEF,
  parameter int unsigned LINE_COUNT = LINE_COUNT_DEF,
  parameter int unsigned WRAP_ROWS  = WRAP_ROWS_DEF
) (
  input logic        clk_i,
  input logic        rst_ni,
  ttcw_cmd_if.sink   cmd_i,
  ttcw_res_if.source res_o
);

  ttcw_cmd_t ctrl_cmd;
  ttcw_sts_t dp_sts;

  // Sequencer: dispatch a command word, then walk newline, blanking and draw, or clamp, row wrap and offset
  ttcw_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_i.valid),
    .cmd_op_i    (cmd_i.op),
    .cmd_ready_o (cmd_i.ready),
    .sts_i       (dp_sts),
    .cmd_o       (ctrl_cmd)
  );

  // Cursor, write offset, scroll index and the output register
  ttcw_dp #(
    .LINE_WIDTH (LINE_WIDTH),
    .LINE_COUNT (LINE_COUNT),
    .WRAP_ROWS  (WRAP_ROWS)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_op_i           (cmd_i.op),
    .cmd_char_code_i    (cmd_i.char_code),
    .cmd_col_i          (cmd_i.col),
    .cmd_row_i          (cmd_i.row),
    .cmd_i              (ctrl_cmd),
    .sts_o              (dp_sts),
    .res_ready_i        (res_o.ready),
    .res_valid_o        (res_o.valid),
    .res_kind_o         (res_o.kind),
    .res_cell_offset_o  (res_o.cell_offset),
    .res_tile_o         (res_o.tile),
    .res_scroll_value_o (res_o.scroll_value),
    .res_last_o         (res_o.last)
  );

endmodule

>>> src/ttcw_checker.sv
module ttcw_checker import ttcw_pkg::*; (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                cmd_valid_i,
  input logic                cmd_ready_i,
  input logic [OP_W-1:0]     cmd_op_i,
  input logic                res_valid_i,
  input logic                res_ready_i,
  input logic                res_kind_i,
  input logic [OFS_W-1:0]    res_cell_offset_i,
  input logic [TILE_W-1:0]   res_tile_i,
  input logic [SCROLL_W-1:0] res_scroll_value_i,
  input logic                res_last_i
);

  logic cmd_fire;
  assign cmd_fire = cmd_valid_i && cmd_ready_i;

  // Hold a stalled word
  a_res_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=> res_valid_i)
    else $error("result word dropped while stalled");

  a_res_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && !res_ready_i |=>
      $stable({res_kind_i, res_cell_offset_i, res_tile_i, res_scroll_value_i, res_last_i}))
    else $error("stalled result word changed");

  // A new command never starts while an earlier one is still mid-sequence
  a_cmd_after_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire |-> !(res_valid_i && !res_last_i))
    else $error("command taken before previous last word");

  // Cursor commands emit nothing
  a_goto_silent: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_fire && (cmd_op_i == OP_GOTO || cmd_op_i == OP_MOVE) |=> !$rose(res_valid_i))
    else $error("cursor command produced a word");

  a_scroll_clean: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_i && res_kind_i == KIND_SCROLL |->
      res_cell_offset_i == '0 && res_tile_i == '0 && res_scroll_value_i[2:0] == 3'b0)
    else $error("malformed scroll word");

endmodule

bind tile_text_console_writer_core ttcw_checker u_ttcw_checker (
  .clk_i              (clk_i),
  .rst_ni             (rst_ni),
  .cmd_valid_i        (cmd_i.valid),
  .cmd_ready_i        (cmd_i.ready),
  .cmd_op_i           (cmd_i.op),
  .res_valid_i        (res_o.valid),
  .res_ready_i        (res_o.ready),
  .res_kind_i         (res_o.kind),
  .res_cell_offset_i  (res_o.cell_offset),
  .res_tile_i         (res_o.tile),
  .res_scroll_value_i (res_o.scroll_value),
  .res_last_i         (res_o.last)
);
